>>> hdl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// shared constants and types of the 3x3 median filter
// ----------------------------------------------------------------------------
package mf3_pkg;

   // deepest line supported by the line stores
   localparam int MAX_LINE = 1024;

   localparam int PIX_W = 8;                    // pixel width
   localparam int COL_W = $clog2(MAX_LINE);     // column counter / store address
   localparam int LW_W  = $clog2(MAX_LINE + 1); // line width register
   localparam int ROW_W = 16;                   // row counter and frame height
   localparam int CCOL_W = 10;                  // center column field

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USED_W = PIX_W + CCOL_W + ROW_W;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic CSR_LINE_WIDTH   = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [LW_W-1:0]  LINE_WIDTH_RST   = LW_W'(MAX_LINE);
   localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = ROW_W'(480);
   localparam logic [LW_W-1:0]  LINE_WIDTH_MIN   = LW_W'(3);
   localparam logic [ROW_W-1:0] FRAME_HEIGHT_MIN = ROW_W'(3);

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [8:0]  window_type;

endpackage

>>> hdl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// generic single write, single read memory with registered read (read-first)
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/mf3_median9.sv
// ----------------------------------------------------------------------------
// mf3_median9
// median of nine pixels: sort columns, then median of max-min, mid-mid, min-max
// ----------------------------------------------------------------------------
module mf3_median9 (
   input  mf3_pkg::window_type win,
   output mf3_pkg::pixel_type  median
);
   import mf3_pkg::*;

   pixel_type lo [3];
   pixel_type md [3];
   pixel_type hi [3];
   pixel_type max_lo;
   pixel_type mid_md;
   pixel_type min_hi;

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // sort each group of three
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo[k] = min2(min2(win[3*k], win[3*k+1]), win[3*k+2]);
         hi[k] = max2(max2(win[3*k], win[3*k+1]), win[3*k+2]);
         md[k] = med3(win[3*k], win[3*k+1], win[3*k+2]);
      end
   end

   assign max_lo = max2(max2(lo[0], lo[1]), lo[2]);
   assign min_hi = min2(min2(hi[0], hi[1]), hi[2]);
   assign mid_md = med3(md[0], md[1], md[2]);
   assign median = med3(max_lo, mid_md, min_hi);

endmodule

>>> hdl/median_filter_3x3.sv
// interior pixels pass stage one, then the result register; a held result stalls stage one
// throughput: one pixel per clock if not stalled; each line store: one read and one write a cycle
// border pixels give no result and pass through the pipe without a stall
// reset clears counters, window and valid flags; registers return to 1024 x 480
// line store contents are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster-order 8-bit grayscale pixel stream
// ----------------------------------------------------------------------------
module median_filter_3x3 (
   input  logic                            clock,
   input  logic                            reset,
   // pixel requests
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mf3_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] pixel_value
   input  logic                            req_tuser,  // frame_start
   // filtered results
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mf3_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [7:0] median_value,
                                                       // [17:8] center_col,
                                                       // [33:18] center_row
   output logic                            rsp_tlast,  // frame_last
   // configuration writes
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mf3_pkg::*;

   // configuration registers
   logic [LW_W-1:0]   line_width_ff;
   logic [ROW_W-1:0]  frame_height_ff;
   logic [LW_W-1:0]   width_eff;
   logic [ROW_W-1:0]  height_eff;

   // position counters
   logic [COL_W-1:0]  col_count_ff, col_count_in;
   logic [ROW_W-1:0]  row_count_ff, row_count_in;

   // request side decode
   logic              accept;
   pixel_type         pix_now;
   logic [COL_W-1:0]  col_now;
   logic [ROW_W-1:0]  row_now;
   logic              col_wrap;
   logic              row_wrap;
   logic              interior_now;
   logic              last_now;

   // stage one: request register, store read data arrives alongside
   logic              s1_valid_ff, s1_valid_in;
   pixel_type         s1_pix_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s1_int_ff;
   logic              s1_last_ff;
   logic              s1_byp_ff;
   pixel_type         s1_bypdata_ff;
   logic              s1_fire;
   pixel_type         upper_rdata;
   pixel_type         lower_rdata;
   pixel_type         s1_top;
   pixel_type         s1_mid;

   // window of the two previous columns, oldest first
   pixel_type         win_ff [6];
   window_type        window;
   pixel_type         median;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   pixel_type         rsp_median_ff;
   logic [CCOL_W-1:0] rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic              rsp_last_ff;

   // ------------------------------------------------------------------------
   // configuration, clamped when used
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata[LW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_eff = line_width_ff;
      if (line_width_ff < LINE_WIDTH_MIN) begin
         width_eff = LINE_WIDTH_MIN;
      end else if (line_width_ff > LW_W'(MAX_LINE)) begin
         width_eff = LW_W'(MAX_LINE);
      end
      height_eff = (frame_height_ff < FRAME_HEIGHT_MIN) ? FRAME_HEIGHT_MIN
                                                        : frame_height_ff;
   end

   // ------------------------------------------------------------------------
   // position of the incoming pixel; frame start restarts at the origin
   // ------------------------------------------------------------------------
   assign accept  = req_tvalid && req_tready;
   assign pix_now = req_tdata[PIX_W-1:0];
   assign col_now = req_tuser ? '0 : col_count_ff;
   assign row_now = req_tuser ? '0 : row_count_ff;

   assign col_wrap = (LW_W'(col_now) + LW_W'(1)) >= width_eff;
   assign row_wrap = ((ROW_W+1)'(row_now) + (ROW_W+1)'(1)) >= (ROW_W+1)'(height_eff);

   assign interior_now = (row_now >= ROW_W'(2)) && (col_now >= COL_W'(2));
   assign last_now     = (row_now == height_eff - ROW_W'(1))
                      && (LW_W'(col_now) == width_eff - LW_W'(1));

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_wrap) begin
            col_count_in = '0;
            row_count_in = row_wrap ? '0 : row_now + ROW_W'(1);
         end else begin
            col_count_in = col_now + COL_W'(1);
            row_count_in = row_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // line stores
   // lower: read and written at acceptance (read-first gives the row above)
   // upper: written with the row above once the item leaves stage one;
   //        a read of the same column in that cycle is bypassed
   // ------------------------------------------------------------------------
   mf3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_LINE)
   ) u_lower_store (
      .clock (clock),
      .we    (accept),
      .waddr (col_now),
      .wdata (pix_now),
      .re    (accept),
      .raddr (col_now),
      .rdata (lower_rdata)
   );

   mf3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_LINE)
   ) u_upper_store (
      .clock (clock),
      .we    (s1_fire),
      .waddr (s1_col_ff),
      .wdata (s1_mid),
      .re    (accept),
      .raddr (col_now),
      .rdata (upper_rdata)
   );

   assign s1_mid = lower_rdata;
   assign s1_top = s1_byp_ff ? s1_bypdata_ff : upper_rdata;

   // ------------------------------------------------------------------------
   // stage one; a border item leaves at once, an interior one needs room
   // in the result register
   // ------------------------------------------------------------------------
   assign s1_fire    = s1_valid_ff && (!s1_int_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= pix_now;
         s1_col_ff     <= col_now;
         s1_row_ff     <= row_now;
         s1_int_ff     <= interior_now;
         s1_last_ff    <= last_now;
         s1_byp_ff     <= s1_fire && (s1_col_ff == col_now);
         s1_bypdata_ff <= s1_mid;
      end
   end

   // window shifts by one column per item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_fire) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= s1_top;
         win_ff[4] <= s1_mid;
         win_ff[5] <= s1_pix_ff;
      end
   end

   assign window = {s1_pix_ff, s1_mid, s1_top,
                    win_ff[5], win_ff[4], win_ff[3],
                    win_ff[2], win_ff[1], win_ff[0]};

   mf3_median9 u_median (
      .win    (window),
      .median (median)
   );

   // ------------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_int_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_int_ff) begin
         rsp_median_ff <= median;
         rsp_col_ff    <= CCOL_W'(s1_col_ff - COL_W'(1));
         rsp_row_ff    <= s1_row_ff - ROW_W'(1);
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RSP_USED_W)'(0), rsp_row_ff, rsp_col_ff, rsp_median_ff};

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_s1_hold_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |-> !req_tready)
      else $error("request taken while stage one is held");

   a_bypass_after_write : assert property (@(posedge clock) disable iff (reset)
      $past(accept) && s1_byp_ff |-> $past(s1_fire))
      else $error("upper store bypass without a write");

   a_interior_loads_rsp : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_int_ff) |=> rsp_valid_ff)
      else $error("interior result lost");

   a_rsp_center_inside : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0))
      else $error("result centred on the top border");

endmodule

>>> test/median_filter_3x3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_checker
// watches the pixel, result and register ports of the median filter, works
// out the filtered result of each accepted interior pixel and compares it with what
// the block returns
// ----------------------------------------------------------------------------
module median_filter_3x3_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mf3_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] pixel_value
   input  logic                            req_tuser,  // frame_start
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mf3_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [7:0] median_value,
                                                       // [17:8] center_col,
                                                       // [33:18] center_row
   input  logic                            rsp_tlast,  // frame_last
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatches,
   output int                              outstanding,
   output int                              filtered_count
);
   import mf3_pkg::*;

   localparam int REPORT_CAP = 40;

   typedef struct packed {
      pixel_type               median;
      logic [CCOL_W-1:0]       col;
      logic [ROW_W-1:0]        row;
      logic                    last;
   } filtered_pixel_type;

   filtered_pixel_type expected_medians[$];

   logic [LW_W-1:0]  width_reg;
   logic [ROW_W-1:0] height_reg;
   pixel_type        upper_row [MAX_LINE];
   pixel_type        lower_row [MAX_LINE];
   pixel_type [5:0]  prev_cols;   // two earlier columns, oldest in the low three
   int unsigned      col_pos;
   int unsigned      row_pos;
   int               reported;

   function automatic int unsigned active_width();
      int unsigned w;
      w = width_reg;
      if (w < LINE_WIDTH_MIN) w = LINE_WIDTH_MIN;
      if (w > MAX_LINE) w = MAX_LINE;
      return w;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = height_reg;
      if (h < FRAME_HEIGHT_MIN) h = FRAME_HEIGHT_MIN;
      return h;
   endfunction

   // the median is the value with at most four below it and at least five at or below it
   function automatic pixel_type median_of_nine(window_type v);
      int below;
      int not_above;
      for (int i = 0; i < 9; i++) begin
         below = 0;
         not_above = 0;
         for (int j = 0; j < 9; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) not_above++;
         end
         if (below <= 4 && not_above >= 5) return v[i];
      end
      return v[4];
   endfunction

   task automatic note_failure(input string msg);
      mismatches++;
      if (reported < REPORT_CAP) $error("%s", msg);
      reported++;
      if (reported == REPORT_CAP) $display("further mismatches are counted but not listed");
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want)
         note_failure($sformatf("%s: expected %0d, actual %0d", name, want, got));
   endtask

   task automatic predict_pixel(input pixel_type px, input logic fs);
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      int unsigned        r;
      int unsigned        idx;
      pixel_type          top;
      pixel_type          mid;
      filtered_pixel_type item;
      w = active_width();
      h = active_height();
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      idx = c % MAX_LINE;
      top = upper_row[idx];
      mid = lower_row[idx];
      upper_row[idx] = mid;
      lower_row[idx] = px;
      if (r >= 2 && c >= 2) begin
         item.median = median_of_nine({px, mid, top, prev_cols});
         item.col    = CCOL_W'(c - 1);
         item.row    = ROW_W'(r - 1);
         item.last   = (r == h - 1) && (c == w - 1);
         expected_medians = {expected_medians, item};
      end
      prev_cols = {px, mid, top, prev_cols[5:3]};
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic check_result();
      filtered_pixel_type want;
      filtered_count++;
      if (expected_medians.size() == 0) begin
         note_failure($sformatf("result with no pixel waiting: median %0d col %0d row %0d",
                                rsp_tdata[PIX_W-1:0], rsp_tdata[PIX_W +: CCOL_W],
                                rsp_tdata[PIX_W+CCOL_W +: ROW_W]));
      end else begin
         want = expected_medians.pop_front();
         compare_field("median_value", want.median, rsp_tdata[PIX_W-1:0]);
         compare_field("center_col", want.col, rsp_tdata[PIX_W +: CCOL_W]);
         compare_field("center_row", want.row, rsp_tdata[PIX_W+CCOL_W +: ROW_W]);
         compare_field("frame_last", want.last, rsp_tlast);
         compare_field("tdata padding", 0, rsp_tdata[RSP_DATA_W-1:RSP_USED_W]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = LINE_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         prev_cols  = '0;
         col_pos    = 0;
         row_pos    = 0;
         for (int i = 0; i < MAX_LINE; i++) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
         end
         expected_medians.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_LINE_WIDTH) width_reg = csr_wdata[LW_W-1:0];
            else height_reg = csr_wdata[ROW_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) predict_pixel(req_tdata[PIX_W-1:0], req_tuser);
      end
      outstanding = expected_medians.size();
   end

endmodule

>>> test/median_filter_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_tb
// streams raster frames of many sizes through the 3x3 median filter, with
// random gaps on both sides and one long result hold-off; a checker beside
// the block predicts every filtered pixel and reports any difference
// ----------------------------------------------------------------------------
module median_filter_3x3_tb;
   import mf3_pkg::*;

   localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
   localparam int PIXEL_BUDGET  = 1100;  // pixel requests over the whole run
   localparam int IDLE_PCT      = 29;
   localparam int CALM_FROM     = 300;   // cycle window with no gaps at all
   localparam int CALM_TO       = 600;
   localparam int HOLD_AFTER    = 120;   // results seen before the long hold-off
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 4;     // result follows its pixel through stage one and the result register
   localparam int WIDE_PHASE    = 0;

   // directed frames, first pixel in the low byte
   localparam logic [71:0] SPLIT_FRAME = {8'd128, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
                                          8'd255, 8'd0, 8'd255};
   localparam logic [71:0] TIED_FRAME  = {8'd7, 8'd200, 8'd200, 8'd200, 8'd7, 8'd200,
                                          8'd7, 8'd7, 8'd7};

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // [7:0] pixel_value
   logic                    req_tuser;   // frame_start
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // [7:0] median_value, [17:8] center_col,
                                         // [33:18] center_row
   logic                    rsp_tlast;   // frame_last
   logic                    csr_we;
   logic                    csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   int        mismatches;
   int        outstanding;
   int        filtered_count;
   int        cycle_no;
   int        quiet_cycles;
   int        pixels_sent;
   int        settings_used;
   int        widest;
   int        cur_width;
   pixel_type last_px;
   bit        hold_done;

   median_filter_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   median_filter_3x3_checker filter_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .filtered_count (filtered_count)
   );

   // 20 ns period, starting low so the first rising edge falls at 10 ns
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // gaps on either side, except inside the calm window
   function automatic bit take_break();
      if (cycle_no >= CALM_FROM && cycle_no < CALM_TO) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   // plenty of extremes and repeats so ties in the window are common
   function automatic pixel_type pick_pixel();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) return 8'd0;
      if (roll < 30) return 8'd255;
      if (roll < 40) return last_px;
      return pixel_type'($urandom_range(255));
   endfunction

   // one pixel request, held until the block takes it
   task automatic send_pixel(input pixel_type px, input logic fs);
      while (take_break()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_DATA_W'(px);
      req_tuser  = fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      pixels_sent++;
      last_px = px;
   endtask

   // block idle: every expected result back, then a wait for border pixels to pass through
   task automatic settle();
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic addr, input int value);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic configure(input int raw_width, input int raw_height, input int eff_width);
      settle();
      write_reg(CSR_LINE_WIDTH, raw_width);
      write_reg(CSR_FRAME_HEIGHT, raw_height);
      settings_used++;
      cur_width = eff_width;
      if (eff_width > widest) widest = eff_width;
   endtask

   // receiver: random gaps, and once a long hold-off so the block backs up
   initial begin
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && filtered_count >= HOLD_AFTER) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_tready = !take_break();
      end
   end

   // watchdog: counts cycles in which nothing at all is accepted
   always @(posedge clock) begin
      cycle_no++;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, outstanding);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int  phase;
      int  eff_w;
      int  eff_h;
      int  raw_w;
      int  raw_h;
      int  frames;
      int  rows;
      int  count;
      int  roll;
      bit  lead_start;
      bit  frame_lead;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_LINE_WIDTH;
      csr_wdata  = '0;
      reset      = 1'b1;
      last_px    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: width written with high junk bits (masks to 3), height below minimum
      configure(16'hF803, 2, 3);
      // smallest frame, alternating extremes, one result that closes the frame
      for (int i = 0; i < 9; i++) send_pixel(SPLIT_FRAME[i*8 +: 8], i == 0);
      // run past the frame end without a frame start, then restart mid-line
      for (int i = 0; i < 4; i++) send_pixel(pixel_type'(8'h11 * (i + 1)), 1'b0);
      for (int i = 0; i < 9; i++) send_pixel(TIED_FRAME[i*8 +: 8], i == 0);

      // random phases: mostly whole frames with random content, plus truncated
      // frames, stray frame starts, overruns and changes of size mid-frame
      phase = 0;
      while (pixels_sent < PIXEL_BUDGET) begin
         if (phase == WIDE_PHASE) begin
            // one wide frame, a quarter of the deepest line across
            eff_w  = MAX_LINE / 4;
            raw_w  = MAX_LINE / 4;
            raw_h  = 3;
            eff_h  = 3;
            frames = 1;
         end else begin
            roll  = $urandom_range(99);
            eff_w = (roll < 70) ? $urandom_range(3, 8) :
                    (roll < 90) ? $urandom_range(9, 24) : 3;
            raw_w = eff_w;
            if (eff_w == 3 && $urandom_range(1) == 1) raw_w = $urandom_range(0, 2);
            roll = $urandom_range(99);
            if (roll < 60) raw_h = $urandom_range(3, 6);
            else if (roll < 75) raw_h = $urandom_range(0, 2);
            else if (roll < 85) raw_h = 16'hFFFF;
            else raw_h = $urandom_range(7, 65535);
            eff_h  = (raw_h < 3) ? 3 : raw_h;
            frames = $urandom_range(1, 3);
         end
         // a narrower or equal width may take over mid-frame: every column it
         // reads was already written; a wider one always starts a fresh frame
         lead_start = !(phase != WIDE_PHASE && eff_w <= cur_width && $urandom_range(99) < 40);
         configure(raw_w, raw_h, eff_w);
         for (int f = 0; f < frames; f++) begin
            rows  = (eff_h > 6) ? $urandom_range(3, 5) : eff_h;
            count = eff_w * rows;
            if (phase != WIDE_PHASE && $urandom_range(99) < 10)
               count = $urandom_range(1, count - 1);
            frame_lead = (f == 0) ? lead_start : ($urandom_range(99) < 75);
            for (int i = 0; i < count; i++)
               send_pixel(pick_pixel(),
                          (i == 0 && frame_lead) ||
                          (phase != WIDE_PHASE && $urandom_range(99) < 2));
         end
         phase++;
      end

      // drain and let any trailing border pixels pass through
      settle();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d pixel requests and %0d filtered results over %0d register settings",
               pixels_sent, filtered_count, settings_used);
      $display("line widths from 3 to %0d, with one long result hold-off", widest);
      if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
